/* hdl/assert_macros.svh */
// Assertion macros used by the envelope sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/adsr_pkg.sv */
// Shared types, constants and command structs of the linear ADSR envelope.
`timescale 1ns / 1ps
`default_nettype none
package adsr_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int INDEX_WIDTH     = 24;
  localparam int LEN_WIDTH       = 24;
  localparam int STEP_WIDTH      = 32;
  localparam int LEVEL_WIDTH     = 8;
  localparam int GAIN_WIDTH      = 16;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int STAGE_WIDTH     = 3;

  localparam logic [GAIN_WIDTH-1:0]  GAIN_MAX            = '1;
  localparam logic [LEN_WIDTH-1:0]   LEN_RESET           = 24'd88200;
  localparam logic [STEP_WIDTH-1:0]  STEP_RESET          = 32'd48695;
  localparam logic [LEVEL_WIDTH-1:0] SUSTAIN_LEVEL_RESET = 8'd255;

  typedef enum logic [STAGE_WIDTH-1:0] {
    STAGE_ATTACK  = 3'd0,
    STAGE_DECAY   = 3'd1,
    STAGE_SUSTAIN = 3'd2,
    STAGE_RELEASE = 3'd3,
    STAGE_SILENT  = 3'd4
  } stage_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ATTACK_LEN    = 3'd0,
    REG_DECAY_LEN     = 3'd1,
    REG_SUSTAIN_LEN   = 3'd2,
    REG_RELEASE_LEN   = 3'd3,
    REG_ATTACK_STEP   = 3'd4,
    REG_DECAY_STEP    = 3'd5,
    REG_RELEASE_STEP  = 3'd6,
    REG_SUSTAIN_LEVEL = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_RAMP    = 2'd0,
    MUL_RELEASE = 2'd1,
    MUL_SCALE   = 2'd2
  } mul_sel_t;

  typedef enum logic [2:0] {
    GAIN_RAMP    = 3'd0,
    GAIN_FALL    = 3'd1,
    GAIN_SUSTAIN = 3'd2,
    GAIN_ZERO    = 3'd3,
    GAIN_PRODUCT = 3'd4
  } gain_sel_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [INDEX_WIDTH-1:0]         sample_index;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic [STAGE_WIDTH-1:0]         stage_now;
  } out_item_t;

  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      load_gain;
    gain_sel_t gain_sel;
    logic      load_start;
    logic      load_out;
    stage_t    stage;
  } dp_cmd_t;

  typedef struct packed {
    logic in_time;
    logic above_sustain;
  } dp_status_t;

endpackage
`default_nettype wire

/* hdl/adsr_ctrl.sv */
// Stage sequencer: walks the envelope stages for one sample and drives the datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module adsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  adsr_pkg::dp_status_t status,
  output adsr_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_REL,
    S_REL_GAIN,
    S_SCALE,
    S_DONE
  } state_t;

  state_t           state;
  state_t           finish_state;
  adsr_pkg::stage_t stage;
  adsr_pkg::stage_t stage_next;
  logic             handover;
  logic             out_free;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.stage    = stage;
    handover     = 1'b0;
    stage_next   = stage;
    finish_state = S_SCALE;
    out_free     = !out_valid || out_ready;
    case (state)
      S_IDLE: cmd.load_in = in_valid;
      S_EVAL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_RAMP;
      end
      S_CHECK: begin
        case (stage)
          adsr_pkg::STAGE_ATTACK: begin
            if (status.in_time) begin
              cmd.load_gain = 1'b1;
              cmd.gain_sel  = adsr_pkg::GAIN_RAMP;
            end else begin
              handover   = 1'b1;
              stage_next = adsr_pkg::STAGE_DECAY;
            end
          end
          adsr_pkg::STAGE_DECAY: begin
            // leave decay once the falling gain reaches the sustain gain or the decay length runs out
            if (status.in_time && status.above_sustain) begin
              cmd.load_gain = 1'b1;
              cmd.gain_sel  = adsr_pkg::GAIN_FALL;
            end else begin
              handover   = 1'b1;
              stage_next = adsr_pkg::STAGE_SUSTAIN;
            end
          end
          adsr_pkg::STAGE_SUSTAIN: begin
            if (status.in_time) begin
              cmd.load_gain = 1'b1;
              cmd.gain_sel  = adsr_pkg::GAIN_SUSTAIN;
            end else begin
              handover   = 1'b1;
              stage_next = adsr_pkg::STAGE_RELEASE;
            end
          end
          adsr_pkg::STAGE_RELEASE: begin
            if (status.in_time) begin
              cmd.load_gain = 1'b1;
              cmd.gain_sel  = adsr_pkg::GAIN_FALL;
              finish_state  = S_REL;
            end else begin
              handover   = 1'b1;
              stage_next = adsr_pkg::STAGE_SILENT;
            end
          end
          default: begin
            cmd.load_gain = 1'b1;
            cmd.gain_sel  = adsr_pkg::GAIN_ZERO;
            stage_next    = adsr_pkg::STAGE_SILENT;
          end
        endcase
        cmd.load_start = handover;
      end
      S_REL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_RELEASE;
      end
      S_REL_GAIN: begin
        cmd.load_gain = 1'b1;
        cmd.gain_sel  = adsr_pkg::GAIN_PRODUCT;
      end
      S_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = adsr_pkg::MUL_SCALE;
      end
      S_DONE: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage     <= adsr_pkg::STAGE_ATTACK;
      out_valid <= 1'b0;
    end else begin
      // raise valid when the result is loaded, drop it once the beat is taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: state <= S_CHECK;
        S_CHECK: begin
          stage <= stage_next;
          state <= handover ? S_EVAL : finish_state;
        end
        S_REL:      state <= S_REL_GAIN;
        S_REL_GAIN: state <= S_SCALE;
        S_SCALE:    state <= S_DONE;
        S_DONE: begin
          // hold the result until the output register frees up
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_one_item_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLY(a_stage_never_back, clk, rst, !$past(rst), stage >= $past(stage))
  `ASSERT_IMPLY(a_load_only_when_free, clk, rst, cmd.load_out, !out_valid || out_ready)
  `ASSERT_NEXT(a_result_shown_after_load, clk, rst, cmd.load_out, out_valid)

endmodule
`default_nettype wire

/* hdl/adsr_datapath.sv */
// Envelope datapath: settings, stage start, shared multiplier, gain and output registers.
`timescale 1ns / 1ps
`default_nettype none
module adsr_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [adsr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [adsr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  adsr_pkg::in_item_t                     in_data,
  output adsr_pkg::out_item_t                    out_data,
  input  adsr_pkg::dp_cmd_t                      cmd,
  output adsr_pkg::dp_status_t                   status
);

  localparam int SW    = adsr_pkg::SAMPLE_WIDTH;
  localparam int IW    = adsr_pkg::INDEX_WIDTH;
  localparam int LW    = adsr_pkg::LEN_WIDTH;
  localparam int PW    = adsr_pkg::STEP_WIDTH;
  localparam int GW    = adsr_pkg::GAIN_WIDTH;
  localparam int LVW   = adsr_pkg::LEVEL_WIDTH;
  localparam int MUL_W = PW + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CMP_W = (IW > LW) ? IW : LW;

  logic [LW-1:0]  attack_len;
  logic [LW-1:0]  decay_len;
  logic [LW-1:0]  sustain_len;
  logic [LW-1:0]  release_len;
  logic [PW-1:0]  attack_step;
  logic [PW-1:0]  decay_step;
  logic [PW-1:0]  release_step;
  logic [LVW-1:0] sustain_level;

  logic [IW-1:0]          stage_start;
  logic [IW-1:0]          idx;
  logic signed [SW-1:0]   sample;
  logic [GW-1:0]          gain;
  logic signed [PROD_W-1:0] prod;

  logic [IW-1:0]          elapsed;
  logic [IW-1:0]          t_sel;
  logic [LW-1:0]          len_sel;
  logic [PW-1:0]          step_sel;
  logic [GW-1:0]          ramp;
  logic [GW-1:0]          fall;
  logic [GW-1:0]          sustain_gain;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= adsr_pkg::LEN_RESET;
      decay_len     <= adsr_pkg::LEN_RESET;
      sustain_len   <= adsr_pkg::LEN_RESET;
      release_len   <= adsr_pkg::LEN_RESET;
      attack_step   <= adsr_pkg::STEP_RESET;
      decay_step    <= adsr_pkg::STEP_RESET;
      release_step  <= adsr_pkg::STEP_RESET;
      sustain_level <= adsr_pkg::SUSTAIN_LEVEL_RESET;
    end else if (cfg_we) begin
      case (adsr_pkg::cfg_reg_t'(cfg_index))
        adsr_pkg::REG_ATTACK_LEN:    attack_len    <= cfg_data[LW-1:0];
        adsr_pkg::REG_DECAY_LEN:     decay_len     <= cfg_data[LW-1:0];
        adsr_pkg::REG_SUSTAIN_LEN:   sustain_len   <= cfg_data[LW-1:0];
        adsr_pkg::REG_RELEASE_LEN:   release_len   <= cfg_data[LW-1:0];
        adsr_pkg::REG_ATTACK_STEP:   attack_step   <= cfg_data[PW-1:0];
        adsr_pkg::REG_DECAY_STEP:    decay_step    <= cfg_data[PW-1:0];
        adsr_pkg::REG_RELEASE_STEP:  release_step  <= cfg_data[PW-1:0];
        adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level <= cfg_data[LVW-1:0];
        default: ;
      endcase
    end
  end

  // attack runs on the absolute index, the other stages on time since stage start
  assign elapsed      = idx - stage_start;
  assign t_sel        = (cmd.stage == adsr_pkg::STAGE_ATTACK) ? idx : elapsed;
  assign sustain_gain = {sustain_level, sustain_level};

  always_comb begin
    case (cmd.stage)
      adsr_pkg::STAGE_ATTACK: begin
        len_sel  = attack_len;
        step_sel = attack_step;
      end
      adsr_pkg::STAGE_DECAY: begin
        len_sel  = decay_len;
        step_sel = decay_step;
      end
      adsr_pkg::STAGE_SUSTAIN: begin
        len_sel  = sustain_len;
        step_sel = '0;
      end
      adsr_pkg::STAGE_RELEASE: begin
        len_sel  = release_len;
        step_sel = release_step;
      end
      default: begin
        len_sel  = '0;
        step_sel = '0;
      end
    endcase
  end

  // saturate the ramp product at full scale
  assign ramp = (|prod[PROD_W-1:2*GW]) ? adsr_pkg::GAIN_MAX : prod[2*GW-1:GW];
  assign fall = adsr_pkg::GAIN_MAX - ramp;

  assign status.in_time       = CMP_W'(t_sel) < CMP_W'(len_sel);
  assign status.above_sustain = fall > sustain_gain;

  always_comb begin
    case (cmd.mul_sel)
      adsr_pkg::MUL_RAMP: begin
        mul_a = $signed({1'b0, step_sel});
        mul_b = $signed({{(MUL_W-IW){1'b0}}, t_sel});
      end
      adsr_pkg::MUL_RELEASE: begin
        mul_a = $signed({{(MUL_W-GW){1'b0}}, gain});
        mul_b = $signed({{(MUL_W-GW){1'b0}}, sustain_gain});
      end
      adsr_pkg::MUL_SCALE: begin
        mul_a = $signed({{(MUL_W-SW){sample[SW-1]}}, sample});
        mul_b = $signed({{(MUL_W-GW){1'b0}}, gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_start <= '0;
    end else if (cmd.load_start) begin
      stage_start <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx    <= in_data.sample_index;
      sample <= in_data.sample_in;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.load_gain) begin
      case (cmd.gain_sel)
        adsr_pkg::GAIN_RAMP:    gain <= ramp;
        adsr_pkg::GAIN_FALL:    gain <= fall;
        adsr_pkg::GAIN_SUSTAIN: gain <= sustain_gain;
        adsr_pkg::GAIN_PRODUCT: gain <= prod[2*GW-1:GW];
        default:                gain <= '0;
      endcase
    end
    // floor of sample times gain over 2^16: arithmetic shift of the product
    if (cmd.load_out) begin
      out_data.sample_out <= prod[GW+SW-1:GW];
      out_data.stage_now  <= cmd.stage;
    end
  end

endmodule
`default_nettype wire

/* hdl/adsr_envelope_linear.sv */
// Top level of the linear ADSR envelope: sequencer plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Scales each signed sample by a linear attack/decay/sustain/release gain
// (Q0.16) chosen from the sample index and the stage the block is in; the
// stage reported with each result is the one in force after that sample.
// One sample is in flight at a time. Per sample the sequencer forms the ramp
// product (EVAL), checks the stage (CHECK), scales the sample (SCALE) and
// loads the output (DONE, held while the output is busy); release adds a
// product scaling the release ramp by the sustain gain (REL, REL_GAIN), and
// each stage that hands over within the same sample repeats EVAL and CHECK;
// all products go through one shared 33x33 multiplier, one product per cycle.
// A finished result waits in the output register while the next sample is
// taken. The user must write settings through the cfg port only while the
// block is idle; the block does not enforce this. Lengths and steps are
// independent registers, so a stage's step should be round(2^32 / length).
module adsr_envelope_linear (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  adsr_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output adsr_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [adsr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [adsr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  adsr_pkg::dp_cmd_t    cmd;
  adsr_pkg::dp_status_t status;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  adsr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the linear ADSR envelope: directed table, then staged random note.
`timescale 1ns / 1ps
module testbench;
  import adsr_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int TIMEOUT_NS    = 1_000_000;

  typedef enum logic { ROW_WRITE, ROW_BEAT } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_sel;
    logic [31:0] value;
    in_item_t    beat;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  in_item_t                   in_data;
  logic                       out_valid;
  logic                       out_ready;
  out_item_t                  out_data;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  // Fixed expectation that travels with the beat it belongs to.
  bit        beat_typed;
  out_item_t beat_want;

  // Shadow of the register file.
  logic [LEN_WIDTH-1:0]   cfg_attack_len  = LEN_RESET;
  logic [LEN_WIDTH-1:0]   cfg_decay_len   = LEN_RESET;
  logic [LEN_WIDTH-1:0]   cfg_sustain_len = LEN_RESET;
  logic [LEN_WIDTH-1:0]   cfg_release_len = LEN_RESET;
  logic [STEP_WIDTH-1:0]  cfg_attack_step  = STEP_RESET;
  logic [STEP_WIDTH-1:0]  cfg_decay_step   = STEP_RESET;
  logic [STEP_WIDTH-1:0]  cfg_release_step = STEP_RESET;
  logic [LEVEL_WIDTH-1:0] cfg_sustain_level = SUSTAIN_LEVEL_RESET;

  // Envelope state as the bench sees it.
  stage_t                 env_stage = STAGE_ATTACK;
  logic [INDEX_WIDTH-1:0] env_start = '0;

  out_item_t              scaled_due[$];
  plan_row_t              plan[$];
  int                     bad_beats = 0;
  int                     burst_left = 0;
  logic [INDEX_WIDTH-1:0] last_idx = '0;
  stage_t                 phase_order [5] =
    '{STAGE_ATTACK, STAGE_DECAY, STAGE_SUSTAIN, STAGE_RELEASE, STAGE_SILENT};

  adsr_envelope_linear DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [GAIN_WIDTH-1:0] ramp_q16(input logic [31:0] step,
                                                     input logic [23:0] t);
    logic [55:0] prod;
    prod = step * t;
    if (prod[55:16] > 40'hFFFF) return GAIN_MAX;
    return prod[31:16];
  endfunction

  // floor(sample * gain / 2^16), low bits kept
  function automatic logic signed [15:0] scale_by_gain(input logic signed [15:0] s,
                                                       input logic [15:0] g);
    logic signed [33:0] prod;
    prod = s * $signed({1'b0, g});
    return prod[31:16];
  endfunction

  function automatic out_item_t envelope_step(input in_item_t it);
    logic [INDEX_WIDTH-1:0] idx;
    logic [INDEX_WIDTH-1:0] t;
    logic [GAIN_WIDTH-1:0]  sg;
    logic [GAIN_WIDTH-1:0]  fall;
    logic [GAIN_WIDTH-1:0]  gain;
    logic [31:0]            rel;
    logic                   done;
    int                     k;
    out_item_t              r;
    idx  = it.sample_index;
    sg   = 16'(cfg_sustain_level * 257);
    gain = '0;
    done = 1'b0;
    // A stage that has run out hands over within the same beat.
    for (k = 0; k < 6 && !done; k++) begin
      t = idx - env_start;
      case (env_stage)
        STAGE_ATTACK: begin
          if (idx < cfg_attack_len) begin
            gain = ramp_q16(cfg_attack_step, idx);
            done = 1'b1;
          end else begin
            env_stage = STAGE_DECAY;
            env_start = idx;
          end
        end
        STAGE_DECAY: begin
          fall = GAIN_MAX - ramp_q16(cfg_decay_step, t);
          if (t < cfg_decay_len && fall > sg) begin
            gain = fall;
            done = 1'b1;
          end else begin
            env_stage = STAGE_SUSTAIN;
            env_start = idx;
          end
        end
        STAGE_SUSTAIN: begin
          if (t < cfg_sustain_len) begin
            gain = sg;
            done = 1'b1;
          end else begin
            env_stage = STAGE_RELEASE;
            env_start = idx;
          end
        end
        STAGE_RELEASE: begin
          if (t < cfg_release_len) begin
            rel  = (GAIN_MAX - ramp_q16(cfg_release_step, t)) * sg;
            gain = rel[31:16];
            done = 1'b1;
          end else begin
            env_stage = STAGE_SILENT;
            env_start = idx;
          end
        end
        default: begin
          env_stage = STAGE_SILENT;
          gain = '0;
          done = 1'b1;
        end
      endcase
    end
    r.sample_out = scale_by_gain(it.sample_in, gain);
    r.stage_now  = env_stage;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t due;
    out_item_t seen;
    if (!rst && in_valid && in_ready) begin
      due = envelope_step(in_data);
      if (beat_typed) due = beat_want;
      scaled_due.push_back(due);
    end
    if (!rst && out_valid && out_ready) begin
      seen = out_data;
      if (scaled_due.size() == 0) begin
        $display("%0t: unexpected beat, sample_out %0d stage_now %0d",
                 $time, seen.sample_out, seen.stage_now);
        bad_beats++;
      end else begin
        due = scaled_due.pop_front();
        if (seen.sample_out !== due.sample_out) begin
          $display("%0t: sample_out expected %0d got %0d",
                   $time, due.sample_out, seen.sample_out);
          bad_beats++;
        end
        if (seen.stage_now !== due.stage_now) begin
          $display("%0t: stage_now expected %0d got %0d",
                   $time, due.stage_now, seen.stage_now);
          bad_beats++;
        end
      end
    end
  end

  // Receiver: stall pattern switches at random between always ready, coin-flip, mostly stalled and toggling.
  initial begin : receiver
    int mode;
    int span;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  function automatic void add_write(input cfg_reg_t sel, input logic [31:0] v);
    plan_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_sel = sel;
    row.value   = v;
    row.beat    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_beat(input logic signed [15:0] s, input logic [23:0] i,
                                   input bit typed, input logic signed [15:0] ws,
                                   input stage_t wst);
    plan_row_t row;
    row.kind              = ROW_BEAT;
    row.reg_sel           = REG_ATTACK_LEN;
    row.value             = '0;
    row.beat.sample_in    = s;
    row.beat.sample_index = i;
    row.typed             = typed;
    row.want.sample_out   = ws;
    row.want.stage_now    = wst;
    plan.push_back(row);
  endfunction

  function automatic logic [23:0] pick_len();
    case ($urandom_range(0, 7))
      0:       return 24'd1;
      1:       return 24'hFFFFFF;
      2, 3:    return 24'($urandom_range(1, 255));
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [31:0] pick_step(input logic [23:0] len);
    logic [63:0] q;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3: begin
        q = ((64'd1 << 33) / len + 64'd1) >> 1;
        return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 19))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] next_index(input stage_t target, input bit entering);
    int pick;
    pick = $urandom_range(0, 99);
    if (entering) return 24'($urandom_range(1, 24'hFFFFFF));
    if (target == STAGE_ATTACK) begin
      if (pick < 75 && last_idx + 1 < cfg_attack_len) return 24'(last_idx + 1);
      return 24'($urandom_range(0, cfg_attack_len - 1));
    end
    if (pick < 70) return 24'(last_idx + 1);
    if (pick < 80) return 24'(last_idx + $urandom_range(2, 16));
    // step back by at least two so the elapsed count wraps but stays short of the length
    if (pick < 88) return 24'(last_idx - $urandom_range(2, 64));
    if (pick < 95) return 24'($urandom);
    return last_idx;
  endfunction

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    in_valid   <= 1'b1;
    in_data    <= it;
    beat_typed <= typed;
    beat_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_idx = it.sample_index;
  endtask

  // Hold valid high for a burst, then drop it for a random gap.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scaled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= v;
    @(posedge clk);
    case (sel)
      REG_ATTACK_LEN:    cfg_attack_len    = v[23:0];
      REG_DECAY_LEN:     cfg_decay_len     = v[23:0];
      REG_SUSTAIN_LEN:   cfg_sustain_len   = v[23:0];
      REG_RELEASE_LEN:   cfg_release_len   = v[23:0];
      REG_ATTACK_STEP:   cfg_attack_step   = v;
      REG_DECAY_STEP:    cfg_decay_step    = v;
      REG_RELEASE_STEP:  cfg_release_step  = v;
      REG_SUSTAIN_LEVEL: cfg_sustain_level = v[7:0];
      default: ;
    endcase
  endtask

  // Random settings, with the registers of the target stage chosen to hold the note there
  // (or to push it into the target on the first beat).
  task automatic configure_for(input stage_t target);
    logic [23:0] a_len;
    logic [23:0] d_len;
    logic [23:0] s_len;
    logic [23:0] r_len;
    logic [31:0] a_step;
    logic [31:0] d_step;
    logic [31:0] r_step;
    logic [7:0]  lvl;
    a_len = pick_len();
    d_len = pick_len();
    s_len = pick_len();
    r_len = pick_len();
    case (target)
      STAGE_ATTACK:  a_len = 24'($urandom_range(1 << 20, 24'hFFFFFF));
      STAGE_DECAY: begin
        a_len = 24'd1;
        d_len = 24'hFFFFFF;
      end
      STAGE_SUSTAIN: begin
        d_len = 24'hFFFFFF;
        s_len = 24'hFFFFFF;
      end
      STAGE_RELEASE: begin
        s_len = 24'd0;
        r_len = 24'hFFFFFF;
      end
      default:       r_len = 24'd1;
    endcase
    a_step = pick_step(a_len);
    d_step = pick_step(d_len);
    r_step = pick_step(r_len);
    case ($urandom_range(0, 5))
      0:       lvl = 8'd0;
      1:       lvl = 8'd255;
      default: lvl = 8'($urandom);
    endcase
    if (target == STAGE_DECAY) begin
      // keep the fall well above the sustain gain
      d_step = $urandom_range(0, 200);
      lvl    = 8'($urandom_range(0, 32));
    end
    // saturated fall reaches the sustain gain at once
    if (target == STAGE_SUSTAIN) d_step = '1;
    write_reg(REG_ATTACK_LEN, {8'd0, a_len});
    write_reg(REG_DECAY_LEN, {8'd0, d_len});
    write_reg(REG_SUSTAIN_LEN, {8'd0, s_len});
    write_reg(REG_RELEASE_LEN, {8'd0, r_len});
    write_reg(REG_ATTACK_STEP, a_step);
    write_reg(REG_DECAY_STEP, d_step);
    write_reg(REG_RELEASE_STEP, r_step);
    write_reg(REG_SUSTAIN_LEVEL, {24'd0, lvl});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t it;
    int       p;
    int       sub;
    int       n;
    int       count;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    beat_typed = 1'b0;
    beat_want  = '0;

    // Directed: attack ramp under reset settings, then the step extremes.
    add_beat(16'sh7FFF, 24'd0, 1'b1, 16'sd0, STAGE_ATTACK);
    add_beat(16'sh8000, 24'd0, 1'b1, 16'sd0, STAGE_ATTACK);
    add_beat(16'sh8000, 24'd88199, 1'b0, '0, STAGE_ATTACK);
    add_beat(16'sh7FFF, 24'd44100, 1'b0, '0, STAGE_ATTACK);
    add_beat(-16'sd1, 24'd1, 1'b0, '0, STAGE_ATTACK);
    add_write(REG_ATTACK_LEN, 32'hFFFFFF);
    add_beat(16'shAAAA, 24'h555555, 1'b0, '0, STAGE_ATTACK);
    add_beat(16'sh5555, 24'hAAAAAA, 1'b0, '0, STAGE_ATTACK);
    add_beat(16'sh7FFF, 24'hFFFFFE, 1'b0, '0, STAGE_ATTACK);
    add_write(REG_ATTACK_STEP, 32'hFFFFFFFF);
    add_beat(16'sh8000, 24'd1, 1'b0, '0, STAGE_ATTACK);
    add_beat(16'sh7FFF, 24'd2, 1'b0, '0, STAGE_ATTACK);
    add_write(REG_ATTACK_STEP, 32'd0);
    add_beat(16'sh8000, 24'hFFFFFE, 1'b1, 16'sd0, STAGE_ATTACK);
    add_beat(16'sh7FFF, 24'd77, 1'b1, 16'sd0, STAGE_ATTACK);
    add_write(REG_ATTACK_STEP, 32'd256);
    add_beat(16'sd12345, 24'd100, 1'b0, '0, STAGE_ATTACK);
    add_beat(-16'sd12345, 24'h800000, 1'b0, '0, STAGE_ATTACK);
    add_beat(16'sd1, 24'h00FFFF, 1'b0, '0, STAGE_ATTACK);
    add_beat(-16'sd2, 24'd3, 1'b0, '0, STAGE_ATTACK);
    add_write(REG_ATTACK_STEP, 32'd1);
    add_beat(16'sh7FFF, 24'hFFFFFE, 1'b0, '0, STAGE_ATTACK);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[r].reg_sel, plan[r].value);
        cfg_we <= 1'b0;
      end else begin
        push_item(plan[r].beat, plan[r].typed, plan[r].want);
        pace();
      end
    end

    // Random: walk one note through every stage, rewriting the settings registers between runs.
    for (p = 0; p < 5; p++) begin
      for (sub = 0; sub < ((p == 4) ? 3 : 5); sub++) begin
        drain();
        configure_for(phase_order[p]);
        count = $urandom_range(30, 50);
        for (n = 0; n < count; n++) begin
          it.sample_in    = pick_sample();
          it.sample_index = next_index(phase_order[p], p != 0 && sub == 0 && n == 0);
          push_item(it, 1'b0, '0);
          pace();
        end
      end
    end

    drain();
    if (bad_beats == 0 && scaled_due.size() == 0) begin
      $display("PASS adsr_envelope_linear");
    end else begin
      $display("FAIL adsr_envelope_linear");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL adsr_envelope_linear");
    $finish;
  end

endmodule
